// ===== rtl/core/assert_macros.svh =====
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain clocked assertion, disabled while reset is asserted.
`define ASSERT_AT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Implication form: whenever pre holds, post must hold in the same cycle.
`define ASSERT_IMPL(label, clk, rst_n, pre, post, msg) \
    `ASSERT_AT(label, clk, rst_n, (pre) |-> (post), msg)

`endif

// ===== rtl/core/ibcc_pkg.sv =====
package ibcc_pkg;

    localparam int NUM_AXES = 3;
    localparam int NUM_SUMS = 6;
    localparam logic [2:0] SEQ_IDLE  = 3'd6;
    localparam logic [2:0] ACC_Z_IDX = 3'd2;
    localparam logic [2:0] LAST_IDX  = 3'd5;

    localparam logic [14:0] ONE_G_RESET = 15'd16384;

    // Gyro: c * 250 / 41, divide by exact reciprocal (m < 2^23)
    localparam logic [7:0]  GYRO_SCALE = 8'd250;
    localparam int          GYRO_SHIFT = 29;
    localparam logic [23:0] GYRO_RECIP = 24'(((1 << GYRO_SHIFT) + 40) / 41);

    // Temp: (3653*17 + 5*t) / 17, divide by exact reciprocal (m < 2^18)
    localparam logic signed [18:0] TEMP_OFFSET = 19'sd62101;
    localparam logic signed [18:0] TEMP_SCALE  = 19'sd5;
    localparam int                 TEMP_SHIFT  = 23;
    localparam logic [18:0]        TEMP_RECIP  = 19'(((1 << TEMP_SHIFT) + 16) / 17);

    localparam int MID_DEPTH = 2;
    localparam int OUT_DEPTH = 4;
    localparam int OUT_CNT_W = $clog2(OUT_DEPTH + 1);

    localparam int GYRO_OUT_MAX = 199805;
    localparam int TEMP_OUT_MIN = -5985;
    localparam int TEMP_OUT_MAX = 13291;

    typedef struct packed {
        logic [NUM_AXES-1:0][15:0] accel;
        logic [NUM_AXES-1:0][15:0] gyro;
        logic [15:0]               temp;
        logic [7:0]                progress;
        logic                      done;
    } mid_item_t;

    typedef struct packed {
        logic [NUM_AXES-1:0][15:0] accel;
        logic [NUM_AXES-1:0][18:0] gyro;
        logic [14:0]               temp;
        logic [7:0]                progress;
        logic                      done;
    } out_item_t;

endpackage

// ===== rtl/core/ibcc_fifo.sv =====
module ibcc_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       push,
    input  logic [WIDTH-1:0]           wr_data,
    input  logic                       pop,
    output logic [WIDTH-1:0]           rd_data,
    output logic                       full,
    output logic                       empty,
    output logic [$clog2(DEPTH+1)-1:0] count
);

    // DEPTH must be a power of two so the pointers wrap on their own.
    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [AW-1:0]    wr_ptr_reg;
    logic [AW-1:0]    rd_ptr_reg;
    logic [CW-1:0]    count_reg;
    logic [CW-1:0]    count_next;

    always_comb
    begin
        count_next = count_reg + CW'(push) - CW'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + AW'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + AW'(1);
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

    assign rd_data = mem_reg[rd_ptr_reg];
    assign full    = (count_reg == CW'(DEPTH));
    assign empty   = (count_reg == '0);
    assign count   = count_reg;

endmodule

// ===== rtl/core/ibcc_front.sv =====
module ibcc_front #(
    parameter int CALIB_SAMPLES = 200
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                accept,
    input  logic                                func,
    input  logic [ibcc_pkg::NUM_AXES-1:0][15:0] accel_raw,
    input  logic [ibcc_pkg::NUM_AXES-1:0][15:0] gyro_raw,
    input  logic [15:0]                         temp_raw,
    input  logic [14:0]                         one_g_counts,
    output logic                                busy,
    output ibcc_pkg::mid_item_t                 mid_item
);

    localparam logic [7:0]  CNT_LIMIT = 8'(CALIB_SAMPLES);
    localparam logic [31:0] DIV_RECIP = 32'((64'd1 << 31) / CALIB_SAMPLES);

    logic [23:0] sum_reg  [ibcc_pkg::NUM_SUMS];
    logic [15:0] bias_reg [ibcc_pkg::NUM_SUMS];
    logic [7:0]  count_reg;
    logic        busy_reg;
    logic [2:0]  issue_reg;

    // bias divide pipeline: |sum| -> approx quotient -> q*N -> correct
    logic        s1_v_reg, s2_v_reg, s3_v_reg;
    logic [2:0]  s1_idx_reg, s2_idx_reg, s3_idx_reg;
    logic        s1_neg_reg, s2_neg_reg, s3_neg_reg;
    logic [22:0] s1_mag_reg, s2_mag_reg, s3_mag_reg;
    logic [22:0] s2_q0_reg, s3_q0_reg;
    logic [22:0] s3_qn_reg;

    logic [7:0]  cnt_inc;
    logic        complete;
    logic        calib_acc;
    logic        issuing;
    logic [23:0] rd_sum;
    logic [23:0] rd_abs;
    logic [54:0] recip_prod;
    logic [30:0] qn_full;
    logic [22:0] rem;
    logic [22:0] q_fix;
    logic [23:0] q_signed;
    logic [15:0] new_bias;
    logic        last_wb;

    always_comb
    begin
        cnt_inc   = count_reg + 8'd1;
        calib_acc = accept && func;
        complete  = calib_acc && (cnt_inc >= CNT_LIMIT);
        issuing   = (issue_reg != ibcc_pkg::SEQ_IDLE);

        for (int i = 0; i < ibcc_pkg::NUM_AXES; i++)
        begin
            mid_item.accel[i] = accel_raw[i] - bias_reg[i];
            mid_item.gyro[i]  = gyro_raw[i] - bias_reg[ibcc_pkg::NUM_AXES + i];
        end
        mid_item.temp     = temp_raw;
        mid_item.progress = func ? cnt_inc : count_reg;
        mid_item.done     = func && (cnt_inc >= CNT_LIMIT);

        rd_sum     = issuing ? sum_reg[issue_reg] : '0;
        rd_abs     = rd_sum[23] ? (~rd_sum + 24'd1) : rd_sum;
        recip_prod = 55'(s1_mag_reg) * 55'(DIV_RECIP);
        qn_full    = 31'(s2_q0_reg) * 31'(CALIB_SAMPLES);

        // approximate quotient is low by at most one
        rem      = s3_mag_reg - s3_qn_reg;
        q_fix    = (rem >= 23'(CALIB_SAMPLES)) ? (s3_q0_reg + 23'd1) : s3_q0_reg;
        q_signed = s3_neg_reg ? -{1'b0, q_fix} : {1'b0, q_fix};
        new_bias = q_signed[15:0];
        if (s3_idx_reg == ibcc_pkg::ACC_Z_IDX)
        begin
            new_bias = new_bias - {1'b0, one_g_counts};
        end
        last_wb = s3_v_reg && (s3_idx_reg == ibcc_pkg::LAST_IDX);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < ibcc_pkg::NUM_SUMS; i++)
            begin
                sum_reg[i]  <= '0;
                bias_reg[i] <= '0;
            end
            count_reg <= '0;
            busy_reg  <= 1'b0;
            issue_reg <= ibcc_pkg::SEQ_IDLE;
            s1_v_reg  <= 1'b0;
            s2_v_reg  <= 1'b0;
            s3_v_reg  <= 1'b0;
        end
        else
        begin
            if (calib_acc)
            begin
                for (int i = 0; i < ibcc_pkg::NUM_AXES; i++)
                begin
                    sum_reg[i] <= sum_reg[i] + {{8{accel_raw[i][15]}}, accel_raw[i]};
                    sum_reg[ibcc_pkg::NUM_AXES + i] <= sum_reg[ibcc_pkg::NUM_AXES + i]
                        + {{8{gyro_raw[i][15]}}, gyro_raw[i]};
                end
                count_reg <= complete ? 8'd0 : cnt_inc;
            end

            if (complete)
            begin
                busy_reg  <= 1'b1;
                issue_reg <= 3'd0;
            end
            else if (issuing)
            begin
                issue_reg <= issue_reg + 3'd1;
            end

            s1_v_reg <= issuing;
            s2_v_reg <= s1_v_reg;
            s3_v_reg <= s2_v_reg;

            if (s3_v_reg)
            begin
                bias_reg[s3_idx_reg] <= new_bias;
            end
            if (last_wb)
            begin
                busy_reg <= 1'b0;
                for (int i = 0; i < ibcc_pkg::NUM_SUMS; i++)
                begin
                    sum_reg[i] <= '0;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        s1_idx_reg <= issue_reg;
        s1_neg_reg <= rd_sum[23];
        s1_mag_reg <= rd_abs[22:0];

        s2_idx_reg <= s1_idx_reg;
        s2_neg_reg <= s1_neg_reg;
        s2_mag_reg <= s1_mag_reg;
        s2_q0_reg  <= recip_prod[53:31];

        s3_idx_reg <= s2_idx_reg;
        s3_neg_reg <= s2_neg_reg;
        s3_mag_reg <= s2_mag_reg;
        s3_q0_reg  <= s2_q0_reg;
        s3_qn_reg  <= qn_full[22:0];
    end

    assign busy = busy_reg;

endmodule

// ===== rtl/core/ibcc_back.sv =====
module ibcc_back (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 mid_empty,
    input  ibcc_pkg::mid_item_t                  mid_item,
    output logic                                 mid_pop,
    input  logic [ibcc_pkg::OUT_CNT_W-1:0]       out_count,
    output logic                                 out_push,
    output ibcc_pkg::out_item_t                  out_item
);

    logic                                  s1_v_reg, s2_v_reg;
    logic [ibcc_pkg::NUM_AXES-1:0][22:0]   s1_gmag_reg;
    logic [ibcc_pkg::NUM_AXES-1:0]         s1_gneg_reg, s2_gneg_reg;
    logic [17:0]                           s1_tmag_reg;
    logic                                  s1_tneg_reg, s2_tneg_reg;
    logic [ibcc_pkg::NUM_AXES-1:0][15:0]   s1_accel_reg, s2_accel_reg;
    logic [7:0]                            s1_prog_reg, s2_prog_reg;
    logic                                  s1_done_reg, s2_done_reg;
    logic [ibcc_pkg::NUM_AXES-1:0][17:0]   s2_gq_reg;
    logic [13:0]                           s2_tq_reg;

    logic [ibcc_pkg::NUM_AXES-1:0][15:0]   g_abs;
    logic [ibcc_pkg::NUM_AXES-1:0][23:0]   g_scaled;
    logic [ibcc_pkg::NUM_AXES-1:0][46:0]   g_prod;
    logic signed [18:0]                    t_val;
    logic [18:0]                           t_abs;
    logic [36:0]                           t_prod;
    logic [ibcc_pkg::OUT_CNT_W:0]          credit_use;

    always_comb
    begin
        // never take more than the output queue can still hold
        credit_use = {1'b0, out_count} + (ibcc_pkg::OUT_CNT_W + 1)'(s1_v_reg)
                   + (ibcc_pkg::OUT_CNT_W + 1)'(s2_v_reg);
        mid_pop    = !mid_empty
                   && (credit_use < (ibcc_pkg::OUT_CNT_W + 1)'(ibcc_pkg::OUT_DEPTH));

        for (int i = 0; i < ibcc_pkg::NUM_AXES; i++)
        begin
            g_abs[i]    = mid_item.gyro[i][15] ? (~mid_item.gyro[i] + 16'd1)
                                               : mid_item.gyro[i];
            g_scaled[i] = 24'(g_abs[i]) * 24'(ibcc_pkg::GYRO_SCALE);
            g_prod[i]   = 47'(s1_gmag_reg[i]) * 47'(ibcc_pkg::GYRO_RECIP);
        end

        t_val  = $signed({{3{mid_item.temp[15]}}, mid_item.temp}) * ibcc_pkg::TEMP_SCALE
               + ibcc_pkg::TEMP_OFFSET;
        t_abs  = t_val[18] ? (~t_val + 19'd1) : t_val;
        t_prod = 37'(s1_tmag_reg) * 37'(ibcc_pkg::TEMP_RECIP);

        out_push = s2_v_reg;
        for (int i = 0; i < ibcc_pkg::NUM_AXES; i++)
        begin
            out_item.accel[i] = s2_accel_reg[i];
            out_item.gyro[i]  = s2_gneg_reg[i] ? -{1'b0, s2_gq_reg[i]} : {1'b0, s2_gq_reg[i]};
        end
        out_item.temp     = s2_tneg_reg ? -{1'b0, s2_tq_reg} : {1'b0, s2_tq_reg};
        out_item.progress = s2_prog_reg;
        out_item.done     = s2_done_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_v_reg <= 1'b0;
            s2_v_reg <= 1'b0;
        end
        else
        begin
            s1_v_reg <= mid_pop;
            s2_v_reg <= s1_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < ibcc_pkg::NUM_AXES; i++)
        begin
            s1_gmag_reg[i] <= g_scaled[i][22:0];
            s2_gq_reg[i]   <= g_prod[i][46:29];
        end
        s1_gneg_reg  <= {mid_item.gyro[2][15], mid_item.gyro[1][15], mid_item.gyro[0][15]};
        s1_tmag_reg  <= t_abs[17:0];
        s1_tneg_reg  <= t_val[18];
        s1_accel_reg <= mid_item.accel;
        s1_prog_reg  <= mid_item.progress;
        s1_done_reg  <= mid_item.done;

        s2_gneg_reg  <= s1_gneg_reg;
        s2_tq_reg    <= t_prod[36:23];
        s2_tneg_reg  <= s1_tneg_reg;
        s2_accel_reg <= s1_accel_reg;
        s2_prog_reg  <= s1_prog_reg;
        s2_done_reg  <= s1_done_reg;
    end

endmodule

// ===== rtl/core/imu_bias_calibrate_convert_core.sv =====
// IMU zero-offset calibration and unit conversion. Each pushed sample is
// corrected with the biases in force when it is taken and passes through the
// mid queue and the back end's s1 and s2 registers into the result queue:
// accel as raw minus bias, gyro in 0.01 deg/s, temperature in 0.01 degC. A
// sample pushed with func high is also summed; the sample that completes
// CALIB_SAMPLES of them reports calib_done and then triggers the bias update,
// during which full stays high while one shared reciprocal-multiply
// pipeline divides the six sums in turn. Otherwise the block takes one
// sample per cycle, limited only by pop on the result side. one_g_counts
// is written through the cfg channel, which is always ready.
module imu_bias_calibrate_convert_core #(
    parameter int CALIB_SAMPLES = 200
) (
    input  logic               clk,
    input  logic               rst_n,

    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [14:0]        cfg_data,

    input  logic               push,
    output logic               full,
    input  logic               func,
    input  logic signed [15:0] accel_x_raw,
    input  logic signed [15:0] accel_y_raw,
    input  logic signed [15:0] accel_z_raw,
    input  logic signed [15:0] temp_raw,
    input  logic signed [15:0] gyro_x_raw,
    input  logic signed [15:0] gyro_y_raw,
    input  logic signed [15:0] gyro_z_raw,

    output logic               empty,
    input  logic               pop,
    output logic signed [15:0] accel_x_out,
    output logic signed [15:0] accel_y_out,
    output logic signed [15:0] accel_z_out,
    output logic signed [18:0] gyro_x_out,
    output logic signed [18:0] gyro_y_out,
    output logic signed [18:0] gyro_z_out,
    output logic signed [14:0] temp_centideg,
    output logic [7:0]         calib_progress,
    output logic               calib_done
);

    logic [14:0]                          one_g_reg;
    logic                                 front_busy;
    logic                                 mid_full;
    logic                                 accept;
    ibcc_pkg::mid_item_t                  front_item;
    ibcc_pkg::mid_item_t                  back_item;
    logic                                 mid_empty;
    logic                                 mid_pop;
    logic                                 out_push;
    ibcc_pkg::out_item_t                  out_wr;
    ibcc_pkg::out_item_t                  out_rd;
    logic [ibcc_pkg::OUT_CNT_W-1:0]       out_count;
    logic                                 out_pop;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            one_g_reg <= ibcc_pkg::ONE_G_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            one_g_reg <= cfg_data;
        end
    end

    assign full   = front_busy || mid_full;
    assign accept = push && !full;

    ibcc_front #(
        .CALIB_SAMPLES(CALIB_SAMPLES)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (accept),
        .func        (func),
        .accel_raw   ({accel_z_raw, accel_y_raw, accel_x_raw}),
        .gyro_raw    ({gyro_z_raw, gyro_y_raw, gyro_x_raw}),
        .temp_raw    (temp_raw),
        .one_g_counts(one_g_reg),
        .busy        (front_busy),
        .mid_item    (front_item)
    );

    ibcc_fifo #(
        .WIDTH($bits(ibcc_pkg::mid_item_t)),
        .DEPTH(ibcc_pkg::MID_DEPTH)
    ) u_mid_q (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (accept),
        .wr_data(front_item),
        .pop    (mid_pop),
        .rd_data(back_item),
        .full   (mid_full),
        .empty  (mid_empty),
        .count  ()
    );

    ibcc_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .mid_empty(mid_empty),
        .mid_item (back_item),
        .mid_pop  (mid_pop),
        .out_count(out_count),
        .out_push (out_push),
        .out_item (out_wr)
    );

    assign out_pop = pop && !empty;

    ibcc_fifo #(
        .WIDTH($bits(ibcc_pkg::out_item_t)),
        .DEPTH(ibcc_pkg::OUT_DEPTH)
    ) u_out_q (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (out_push),
        .wr_data(out_wr),
        .pop    (out_pop),
        .rd_data(out_rd),
        .full   (),
        .empty  (empty),
        .count  (out_count)
    );

    assign accel_x_out    = out_rd.accel[0];
    assign accel_y_out    = out_rd.accel[1];
    assign accel_z_out    = out_rd.accel[2];
    assign gyro_x_out     = out_rd.gyro[0];
    assign gyro_y_out     = out_rd.gyro[1];
    assign gyro_z_out     = out_rd.gyro[2];
    assign temp_centideg  = out_rd.temp;
    assign calib_progress = out_rd.progress;
    assign calib_done     = out_rd.done;

endmodule

// ===== rtl/core/ibcc_checker.sv =====
`include "assert_macros.svh"

module ibcc_checker #(
    parameter int CALIB_SAMPLES = 200
) (
    input logic               clk,
    input logic               rst_n,
    input logic               empty,
    input logic signed [18:0] gyro_x_out,
    input logic signed [18:0] gyro_y_out,
    input logic signed [18:0] gyro_z_out,
    input logic signed [14:0] temp_centideg,
    input logic [7:0]         calib_progress,
    input logic               calib_done
);

    localparam logic signed [19:0] G_MAX = 20'(ibcc_pkg::GYRO_OUT_MAX);
    localparam logic signed [19:0] G_MIN = -20'(ibcc_pkg::GYRO_OUT_MAX);
    localparam logic signed [15:0] T_MAX = 16'(ibcc_pkg::TEMP_OUT_MAX);
    localparam logic signed [15:0] T_MIN = 16'(ibcc_pkg::TEMP_OUT_MIN);
    localparam logic [7:0]         N_CAL = 8'(CALIB_SAMPLES);

    `ASSERT_IMPL(a_done_at_limit, clk, rst_n, !empty && calib_done, calib_progress == N_CAL, "calib_done without full round")
    `ASSERT_IMPL(a_progress_range, clk, rst_n, !empty, calib_progress <= N_CAL, "calib_progress past sample count")
    `ASSERT_IMPL(a_temp_range, clk, rst_n, !empty, 16'(temp_centideg) <= T_MAX && 16'(temp_centideg) >= T_MIN, "temp_centideg out of range")
    `ASSERT_IMPL(a_gyro_range, clk, rst_n, !empty, 20'(gyro_x_out) <= G_MAX && 20'(gyro_x_out) >= G_MIN && 20'(gyro_y_out) <= G_MAX && 20'(gyro_y_out) >= G_MIN && 20'(gyro_z_out) <= G_MAX && 20'(gyro_z_out) >= G_MIN, "gyro output out of range")

endmodule

bind imu_bias_calibrate_convert_core ibcc_checker #(
    .CALIB_SAMPLES(CALIB_SAMPLES)
) u_ibcc_checker (.*);
